[design/tua_pkg.sv]
// ----------------------------------------------------------------------------
// tua_pkg
// Shared constants, operation codes and helpers for the slot allocator.
// ----------------------------------------------------------------------------
package tua_pkg;

  // default sizing of the slot table
  localparam int SLOT_COUNT_DEF  = 16;
  localparam int HANDLE_BITS_DEF = 16;
  localparam int STAMP_BITS_DEF  = 32;

  // fixed field widths of the stream words
  localparam int MODE_W   = 3;
  localparam int SLOT_W   = 6;
  localparam int HNDL_W   = 16;
  localparam int EXCL_W   = 32;
  localparam int INDEX_W  = 5;
  localparam int IN_BITS  = MODE_W + SLOT_W + 2 * HNDL_W + EXCL_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = INDEX_W + 2;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_BIND       = 3'd0;
  localparam logic [MODE_W-1:0] MODE_UNBIND_TEX = 3'd1;
  localparam logic [MODE_W-1:0] MODE_UNBIND_SMP = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR_ALL  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FIND       = 3'd4;

  // index width for a table of n entries, never below one bit
  function automatic int idx_bits(input int n);
    idx_bits = (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

[design/tua_cmp.sv]
// ----------------------------------------------------------------------------
// tua_cmp
// Shared compare unit: equality and unsigned less-than of two operands.
// ----------------------------------------------------------------------------
module tua_cmp #(
  parameter int CMP_BITS = tua_pkg::STAMP_BITS_DEF
) (
  input  logic [CMP_BITS-1:0] a,
  input  logic [CMP_BITS-1:0] b,
  output logic                eq,
  output logic                lt
);

  // one comparator serves handle matching and stamp ordering
  assign eq = (a == b);
  assign lt = (a < b);

endmodule

[design/tua_slot_table.sv]
// ----------------------------------------------------------------------------
// tua_slot_table
// Slot storage: texture, sampler and stamp per slot, one write and one read
// port. A slot never written since reset reads as all zeros.
// ----------------------------------------------------------------------------
module tua_slot_table #(
  parameter int SLOT_COUNT  = tua_pkg::SLOT_COUNT_DEF,
  parameter int HANDLE_BITS = tua_pkg::HANDLE_BITS_DEF,
  parameter int STAMP_BITS  = tua_pkg::STAMP_BITS_DEF,
  localparam int IDX_BITS   = tua_pkg::idx_bits(SLOT_COUNT)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [IDX_BITS-1:0]    wr_idx,
  input  logic [HANDLE_BITS-1:0] wr_tex,
  input  logic [HANDLE_BITS-1:0] wr_smp,
  input  logic [STAMP_BITS-1:0]  wr_stamp,
  input  logic [IDX_BITS-1:0]    rd_idx,
  output logic [HANDLE_BITS-1:0] rd_tex,
  output logic [HANDLE_BITS-1:0] rd_smp,
  output logic [STAMP_BITS-1:0]  rd_stamp
);

  logic [HANDLE_BITS-1:0] tex_mem   [SLOT_COUNT];
  logic [HANDLE_BITS-1:0] smp_mem   [SLOT_COUNT];
  logic [STAMP_BITS-1:0]  stamp_mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0]  valid;

  // valid bits, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_idx] <= 1'b1;
    end
  end

  // payload storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tex_mem[wr_idx]   <= wr_tex;
      smp_mem[wr_idx]   <= wr_smp;
      stamp_mem[wr_idx] <= wr_stamp;
    end
  end

  // read port, unwritten slots read as reset value
  assign rd_tex   = valid[rd_idx] ? tex_mem[rd_idx]   : '0;
  assign rd_smp   = valid[rd_idx] ? smp_mem[rd_idx]   : '0;
  assign rd_stamp = valid[rd_idx] ? stamp_mem[rd_idx] : '0;

endmodule

[design/texture_unit_allocator_unit.sv]
// ----------------------------------------------------------------------------
// texture_unit_allocator_unit
// Least-recently-bound slot table with bind, unbind, clear and find requests.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ stream, one word per operation; every request
//   gives exactly one result word on the m_ stream, through a sequencer that
//   steps a slot index over the table, one slot per cycle, on one comparator.
//   Bind and unused modes go from the scan state straight to the reply;
//   unbind and clear all step over every slot; find stops at the first free
//   slot, else steps over every slot again to search for the oldest one.
//   s_tready is high only while no request is in work and rises in the same
//   cycle that the result is registered; the next request may enter while
//   the last result still waits.
//   A stalled receiver holds the result in the output register; a further
//   finished result then waits in the sequencer until that register frees.
//   Reset empties every slot, zeroes the time counter and drops any result.
// ----------------------------------------------------------------------------
module texture_unit_allocator_unit #(
  parameter int SLOT_COUNT  = tua_pkg::SLOT_COUNT_DEF,
  parameter int HANDLE_BITS = tua_pkg::HANDLE_BITS_DEF,
  parameter int STAMP_BITS  = tua_pkg::STAMP_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // mode[2:0], slot[8:3], texture_handle[24:9], sampler_handle[40:25],
  // exclude_mask[72:41], zero fill above
  input  logic [tua_pkg::IN_W-1:0] s_tdata,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // slot_index[4:0], found[5], was_free[6], zero fill above
  output logic [tua_pkg::OUT_W-1:0] m_tdata
);

  localparam int IDX_BITS = tua_pkg::idx_bits(SLOT_COUNT);
  localparam int CMP_BITS = (HANDLE_BITS > STAMP_BITS) ? HANDLE_BITS : STAMP_BITS;
  localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(SLOT_COUNT - 1);

  // sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_EVICT = 2'd2;
  localparam logic [1:0] ST_REPLY = 2'd3;

  logic [1:0]                  state;
  logic [tua_pkg::MODE_W-1:0]  req_mode;
  logic [tua_pkg::SLOT_W-1:0]  req_slot;
  logic [HANDLE_BITS-1:0]      req_tex;
  logic [HANDLE_BITS-1:0]      req_smp;
  logic [SLOT_COUNT-1:0]       req_excl;
  logic [IDX_BITS-1:0]         idx;
  logic [STAMP_BITS-1:0]       time_now;
  logic [STAMP_BITS-1:0]       oldest;
  logic [IDX_BITS-1:0]         chosen;
  logic                        found;
  logic                        was_free;

  logic [HANDLE_BITS-1:0]      rd_tex;
  logic [HANDLE_BITS-1:0]      rd_smp;
  logic [STAMP_BITS-1:0]       rd_stamp;
  logic                        wr_en;
  logic [IDX_BITS-1:0]         wr_idx;
  logic [HANDLE_BITS-1:0]      wr_tex;
  logic [HANDLE_BITS-1:0]      wr_smp;
  logic [CMP_BITS-1:0]         cmp_a;
  logic [CMP_BITS-1:0]         cmp_b;
  logic                        cmp_eq;
  logic                        cmp_lt;
  logic                        in_fire;
  logic                        bind_ok;
  logic                        last;
  logic                        out_free;

  assign s_tready = (state == ST_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign last     = (idx == LAST_IDX);
  assign out_free = !m_tvalid || m_tready;
  assign bind_ok  = ({1'b0, req_slot} < (tua_pkg::SLOT_W + 1)'(SLOT_COUNT));

  // slot storage
  tua_slot_table #(
    .SLOT_COUNT  (SLOT_COUNT),
    .HANDLE_BITS (HANDLE_BITS),
    .STAMP_BITS  (STAMP_BITS)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_idx   (wr_idx),
    .wr_tex   (wr_tex),
    .wr_smp   (wr_smp),
    .wr_stamp (time_now),
    .rd_idx   (idx),
    .rd_tex   (rd_tex),
    .rd_smp   (rd_smp),
    .rd_stamp (rd_stamp)
  );

  // operand select for the shared comparator
  always_comb begin
    cmp_a = CMP_BITS'(rd_tex);
    cmp_b = '0;
    if (state == ST_EVICT) begin
      cmp_a = CMP_BITS'(rd_stamp);
      cmp_b = CMP_BITS'(oldest);
    end else begin
      case (req_mode)
        tua_pkg::MODE_UNBIND_TEX: cmp_b = CMP_BITS'(req_tex);
        tua_pkg::MODE_UNBIND_SMP: begin
          cmp_a = CMP_BITS'(rd_smp);
          cmp_b = CMP_BITS'(req_smp);
        end
        default: cmp_b = '0;
      endcase
    end
  end

  tua_cmp #(
    .CMP_BITS (CMP_BITS)
  ) u_cmp (
    .a  (cmp_a),
    .b  (cmp_b),
    .eq (cmp_eq),
    .lt (cmp_lt)
  );

  // table write decode
  always_comb begin
    wr_en  = 1'b0;
    wr_idx = idx;
    wr_tex = '0;
    wr_smp = '0;
    if (state == ST_SCAN) begin
      case (req_mode)
        tua_pkg::MODE_BIND: begin
          wr_en  = bind_ok;
          wr_idx = req_slot[IDX_BITS-1:0];
          wr_tex = req_tex;
          wr_smp = req_smp;
        end
        tua_pkg::MODE_UNBIND_TEX: wr_en = cmp_eq;
        tua_pkg::MODE_UNBIND_SMP: wr_en = cmp_eq;
        tua_pkg::MODE_CLEAR_ALL:  wr_en = 1'b1;
        default:                  wr_en = 1'b0;
      endcase
    end
  end

  // global time, one tick per slot written
  always_ff @(posedge clk) begin
    if (rst) begin
      time_now <= '0;
    end else if (wr_en) begin
      time_now <= time_now + 1'b1;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_mode <= s_tdata[2:0];
      req_slot <= s_tdata[8:3];
      req_tex  <= HANDLE_BITS'(s_tdata[24:9]);
      req_smp  <= HANDLE_BITS'(s_tdata[40:25]);
      req_excl <= SLOT_COUNT'(s_tdata[72:41]);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      idx      <= '0;
      found    <= 1'b0;
      was_free <= 1'b0;
      chosen   <= '0;
      oldest   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            state    <= ST_SCAN;
            idx      <= '0;
            found    <= 1'b0;
            was_free <= 1'b0;
            chosen   <= '0;
          end
        end
        ST_SCAN: begin
          case (req_mode)
            tua_pkg::MODE_UNBIND_TEX, tua_pkg::MODE_UNBIND_SMP,
            tua_pkg::MODE_CLEAR_ALL: begin
              if (last) begin
                state <= ST_REPLY;
              end else begin
                idx <= idx + 1'b1;
              end
            end
            tua_pkg::MODE_FIND: begin
              if (cmp_eq) begin
                chosen   <= idx;
                found    <= 1'b1;
                was_free <= 1'b1;
                state    <= ST_REPLY;
              end else if (last) begin
                idx   <= '0;
                state <= ST_EVICT;
              end else begin
                idx <= idx + 1'b1;
              end
            end
            default: state <= ST_REPLY;
          endcase
        end
        ST_EVICT: begin
          // oldest stamp among slots not excluded, lower index on ties
          if (!req_excl[idx] && (!found || cmp_lt)) begin
            chosen <= idx;
            oldest <= rd_stamp;
            found  <= 1'b1;
          end
          if (last) begin
            state <= ST_REPLY;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_REPLY: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_REPLY && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_REPLY && out_free) begin
      m_tdata <= tua_pkg::OUT_W'({was_free, found,
                                  found ? tua_pkg::INDEX_W'(chosen) : '0});
    end
  end

`ifndef NO_ASSERTIONS
  // a result marked free must also be marked found
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[6] && !m_tdata[5]))
    else $error("was_free set without found");

  // no slot chosen means index zero
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[5]) |-> (m_tdata[4:0] == '0))
    else $error("slot_index nonzero without found");

  // time moves by at most one per cycle
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (time_now == $past(time_now) ||
                     time_now == STAMP_BITS'($past(time_now) + 1'b1)))
    else $error("time counter jumped");

  // scan index stays inside the table
  assert property (@(posedge clk) disable iff (rst)
    idx <= LAST_IDX)
    else $error("scan index out of range");

  // time only advances while a request is being scanned
  assert property (@(posedge clk) disable iff (rst)
    (state != ST_SCAN) |=> $stable(time_now))
    else $error("time changed outside a scan");
`endif

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the slot allocator. A scoreboard keeps its own copy
// of the slot table and time counter, and from each accepted request word it
// works out the result word that should come back. Directed requests cover
// the corner cases, and four random phases follow with different amounts of
// idling on the request side and stalling on the result side.
// ----------------------------------------------------------------------------
module testbench;

  localparam int SLOTS      = tua_pkg::SLOT_COUNT_DEF;
  localparam int MODE_W     = tua_pkg::MODE_W;
  localparam int SLOT_W     = tua_pkg::SLOT_W;
  localparam int HNDL_W     = tua_pkg::HNDL_W;
  localparam int EXCL_W     = tua_pkg::EXCL_W;
  localparam int INDEX_W    = tua_pkg::INDEX_W;
  localparam int IN_BITS    = tua_pkg::IN_BITS;
  localparam int IN_W       = tua_pkg::IN_W;
  localparam int OUT_BITS   = tua_pkg::OUT_BITS;
  localparam int OUT_W      = tua_pkg::OUT_W;
  localparam int HOLD_LEN   = 400;
  localparam int QUIET_MAX  = 3000;
  localparam int DRAIN_WAIT = 2 * SLOTS + 8;
  localparam int PHASE_REQS = 255;

  typedef logic [IN_W-1:0]  req_word_t;
  typedef logic [OUT_W-1:0] res_word_t;

  // one slot pick as it shows up on the result stream
  typedef struct packed {
    logic               was_free;
    logic               found;
    logic [INDEX_W-1:0] slot_index;
  } pick_t;

  // shadow slot table plus the queue of picks still owed by the block
  class slot_table_board;
    logic [HNDL_W-1:0] tex_of[SLOTS];
    logic [HNDL_W-1:0] smp_of[SLOTS];
    logic [31:0]       stamp_of[SLOTS];
    logic [31:0]       time_now;
    pick_t             owed_picks[$];
    int errors;
    int requests;
    int finds;
    int evictions;
    int no_slot;
    int ignored_binds;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        tex_of[i] = '0;
        smp_of[i] = '0;
        stamp_of[i] = '0;
      end
      time_now = '0;
      errors = 0;
      requests = 0;
      finds = 0;
      evictions = 0;
      no_slot = 0;
      ignored_binds = 0;
    endfunction

    function void write_slot(int i, logic [HNDL_W-1:0] t, logic [HNDL_W-1:0] s);
      tex_of[i] = t;
      smp_of[i] = s;
      stamp_of[i] = time_now;
      time_now = time_now + 1;
    endfunction

    // apply one accepted request and queue the pick it must produce
    function void note_request(req_word_t w);
      logic [MODE_W-1:0] mode;
      logic [SLOT_W-1:0] slot;
      logic [HNDL_W-1:0] tex;
      logic [HNDL_W-1:0] smp;
      logic [EXCL_W-1:0] excl;
      logic [31:0]       oldest;
      pick_t             p;
      {excl, smp, tex, slot, mode} = w[IN_BITS-1:0];
      p = '0;
      oldest = '0;
      requests++;
      case (mode)
        tua_pkg::MODE_BIND: begin
          if (slot < SLOTS) write_slot(int'(slot), tex, smp);
          else ignored_binds++;
        end
        tua_pkg::MODE_UNBIND_TEX: begin
          for (int i = 0; i < SLOTS; i++)
            if (tex_of[i] == tex) write_slot(i, '0, '0);
        end
        tua_pkg::MODE_UNBIND_SMP: begin
          for (int i = 0; i < SLOTS; i++)
            if (smp_of[i] == smp) write_slot(i, '0, '0);
        end
        tua_pkg::MODE_CLEAR_ALL: begin
          for (int i = 0; i < SLOTS; i++) write_slot(i, '0, '0);
        end
        tua_pkg::MODE_FIND: begin
          finds++;
          // lowest free slot first
          for (int i = 0; i < SLOTS && !p.found; i++) begin
            if (tex_of[i] == '0) begin
              p.slot_index = INDEX_W'(i);
              p.found = 1'b1;
              p.was_free = 1'b1;
            end
          end
          // otherwise oldest stamp among slots not excluded, lower index on ties
          if (!p.found) begin
            for (int i = 0; i < SLOTS; i++) begin
              if (!excl[i] && (!p.found || stamp_of[i] < oldest)) begin
                p.slot_index = INDEX_W'(i);
                p.found = 1'b1;
                oldest = stamp_of[i];
              end
            end
            if (p.found) evictions++;
            else no_slot++;
          end
        end
        default: ;
      endcase
      owed_picks.push_back(p);
    endfunction

    // compare one result word with the oldest owed pick
    function void check_result(res_word_t w);
      pick_t got;
      pick_t want;
      got = w[OUT_BITS-1:0];
      if (owed_picks.size() == 0) begin
        $error("result word 0x%0h with no request outstanding", w);
        errors++;
        return;
      end
      want = owed_picks.pop_front();
      if (got.slot_index !== want.slot_index) begin
        $error("slot_index: expected %0d, got %0d", want.slot_index, got.slot_index);
        errors++;
      end
      if (got.found !== want.found) begin
        $error("found: expected %0d, got %0d", want.found, got.found);
        errors++;
      end
      if (got.was_free !== want.was_free) begin
        $error("was_free: expected %0d, got %0d", want.was_free, got.was_free);
        errors++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      s_tvalid;
  logic      s_tready;
  req_word_t s_tdata;
  logic      m_tvalid;
  logic      m_tready;
  res_word_t m_tdata;

  slot_table_board board;
  int idle_pct;
  int stall_pct;
  bit hold_req;
  int quiet_cycles;

  texture_unit_allocator_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic req_word_t pack_req(logic [MODE_W-1:0] mode, logic [SLOT_W-1:0] slot,
                                         logic [HNDL_W-1:0] tex, logic [HNDL_W-1:0] smp,
                                         logic [EXCL_W-1:0] excl);
    req_word_t w;
    w = '0;
    w[IN_BITS-1:0] = {excl, smp, tex, slot, mode};
    return w;
  endfunction

  // handles mostly from a small pool so unbinds hit, sometimes anything
  function automatic logic [HNDL_W-1:0] pick_handle();
    if ($urandom_range(7) == 0) return HNDL_W'($urandom_range(65535));
    return HNDL_W'($urandom_range(6));
  endfunction

  function automatic req_word_t rand_req();
    int                r;
    logic [MODE_W-1:0] mode;
    logic [SLOT_W-1:0] slot;
    logic [EXCL_W-1:0] excl;
    r = $urandom_range(99);
    if (r < 42)      mode = tua_pkg::MODE_BIND;
    else if (r < 68) mode = tua_pkg::MODE_FIND;
    else if (r < 78) mode = tua_pkg::MODE_UNBIND_TEX;
    else if (r < 88) mode = tua_pkg::MODE_UNBIND_SMP;
    else if (r < 91) mode = tua_pkg::MODE_CLEAR_ALL;
    else             mode = MODE_W'($urandom_range(7, 5));
    if ($urandom_range(9) == 0) slot = SLOT_W'($urandom_range(63, SLOTS));
    else                        slot = SLOT_W'($urandom_range(SLOTS - 1));
    case ($urandom_range(3))
      0: excl = '0;
      1: excl = $urandom;
      2: excl = $urandom | $urandom;
      default: excl = ~(EXCL_W'(1) << $urandom_range(EXCL_W - 1));
    endcase
    return pack_req(mode, slot, pick_handle(), pick_handle(), excl);
  endfunction

  // offer one request word, called and returning at a falling edge
  task automatic send_req(req_word_t w);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    do @(posedge clk); while (!s_tready);
    board.note_request(w);
    @(negedge clk);
  endtask

  // result side: random stalls plus one long hold-off on request
  initial begin
    bit held;
    held = 1'b0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        m_tready <= 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
        held = 1'b1;
      end
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata);
  end

  // count cycles with no word moving on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  // watchdog
  initial begin
    wait (quiet_cycles >= QUIET_MAX);
    $display("timeout: no word moved for %0d cycles", QUIET_MAX);
    $display("== FAIL ==");
    $finish;
  end

  // main sequence
  initial begin
    board = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty table, unused modes, ignored binds
    send_req(pack_req(tua_pkg::MODE_FIND, '0, '0, '0, '0));
    send_req(pack_req(MODE_W'(5), '1, '1, '1, '1));
    send_req(pack_req(MODE_W'(7), '0, '0, '0, '0));
    send_req(pack_req(tua_pkg::MODE_BIND, SLOT_W'(SLOTS), 16'hffff, 16'hffff, '0));
    send_req(pack_req(tua_pkg::MODE_BIND, '1, 16'h0001, 16'h0001, '1));
    // fill the table; slot 5 bound with no texture stays free
    for (int i = 0; i < SLOTS; i++) begin
      if (i == 0)
        send_req(pack_req(tua_pkg::MODE_BIND, '0, '1, '1, '0));
      else if (i == 5)
        send_req(pack_req(tua_pkg::MODE_BIND, SLOT_W'(i), '0, 16'h8001, '0));
      else
        send_req(pack_req(tua_pkg::MODE_BIND, SLOT_W'(i), HNDL_W'(16'h100 + i),
                          HNDL_W'(16'h200 + i), '0));
    end
    send_req(pack_req(tua_pkg::MODE_FIND, '0, '0, '0, '1));
    send_req(pack_req(tua_pkg::MODE_BIND, SLOT_W'(5), 16'h8000, 16'h8001, '0));
    // full table: all excluded, only high mask bits set, oldest excluded
    send_req(pack_req(tua_pkg::MODE_FIND, '0, '0, '0, '1));
    send_req(pack_req(tua_pkg::MODE_FIND, '0, '0, '0, 32'hffff_0000));
    send_req(pack_req(tua_pkg::MODE_FIND, '0, '0, '0, 32'h0000_0001));
    // handle zero matching, clearing by sampler and texture
    send_req(pack_req(tua_pkg::MODE_UNBIND_SMP, '0, '0, 16'h8001, '0));
    send_req(pack_req(tua_pkg::MODE_UNBIND_TEX, '0, '0, '0, '0));
    send_req(pack_req(tua_pkg::MODE_UNBIND_SMP, '0, '0, '0, '0));
    send_req(pack_req(tua_pkg::MODE_CLEAR_ALL, '0, '0, '0, '0));

    // random phases, long receiver hold-off at the start of the first
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  hold_req = 1'b1; end
        1: begin idle_pct = 72; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 72; end
        default: begin idle_pct = 11; stall_pct = 11; end
      endcase
      repeat (PHASE_REQS) send_req(rand_req());
    end
    s_tvalid <= 1'b0;

    // drain
    while (board.owed_picks.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("%0d requests checked: %0d finds, %0d evictions, %0d with no slot",
             board.requests, board.finds, board.evictions, board.no_slot);
    $display("%0d out-of-range binds ignored, %0d mismatches",
             board.ignored_binds, board.errors);
    if (board.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

[sim.f]
design/tua_pkg.sv
design/tua_cmp.sv
design/tua_slot_table.sv
design/texture_unit_allocator_unit.sv
dv/testbench.sv
